// ===== sv/ftt_pkg.sv =====
// Package: shared types, constants and the hash step of the flow table tracker.
`timescale 1ns / 1ps
package ftt_pkg;

	localparam int SLOTS_DEF = 4096;
	// Widest slot index any legal table size needs.
	localparam int HOME_W = 16;
	localparam int STAMP_W = 48;
	localparam int MISC_W = 41;
	localparam int SLOT_OUT_W = 12;
	localparam int HASH_BYTES = 38;
	localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
	localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};

	localparam logic OP_NEW = 1'b0;
	localparam logic OP_DESTROY = 1'b1;
	localparam logic EV_START = 1'b0;
	localparam logic EV_END = 1'b1;

	typedef struct packed {
		logic        operation;
		logic        family;
		logic [7:0]  proto;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [63:0] src_addr_hi;
		logic [63:0] src_addr_lo;
		logic [63:0] dst_addr_hi;
		logic [63:0] dst_addr_lo;
		logic [31:0] flow_mark_in;
		logic [63:0] orig_bytes_in;
		logic [63:0] reply_bytes_in;
	} item_t;

	typedef struct packed {
		logic                  event_kind;
		logic [SLOT_OUT_W-1:0] slot;
		logic [7:0]            proto_out;
		logic                  family_out;
		logic [31:0]           flow_mark_out;
		logic [63:0]           orig_bytes_out;
		logic [63:0]           reply_bytes_out;
	} result_t;

	typedef struct packed {
		logic [STAMP_W-1:0] stamp;
		logic [63:0]        src_hi;
		logic [63:0]        src_lo;
		logic [63:0]        dst_hi;
		logic [63:0]        dst_lo;
		logic [MISC_W-1:0]  misc;
		logic [31:0]        mark;
		logic [63:0]        orig_bytes;
		logic [63:0]        reply_bytes;
	} entry_t;

	typedef struct packed {
		item_t             item;
		logic [HOME_W-1:0] home;
	} job_t;

	typedef struct packed {
		logic clearing;
	} status_t;

	// One FNV-1a step: xor in the byte, then multiply by the 64-bit prime
	// 2^40 + 0x1b3, written as shifts and adds.
	function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
		logic [63:0] x;
		x = h ^ {56'd0, b};
		return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
	endfunction

endpackage

// ===== sv/ftt_ram.sv =====
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
module ftt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== sv/ftt_front.sv =====
// Front end: accepts flow events, hashes the tuple and reduces it to a home slot.
`timescale 1ns / 1ps
module ftt_front import ftt_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	input  status_t status,
	input  logic    q_full,
	output logic    q_push,
	output job_t    q_data
);
	localparam int SW = $clog2(SLOTS);
	localparam int V_W = SW + 8;
	localparam logic [23:0] RECIP = 24'((1 << 24) / SLOTS);
	localparam logic [16:0] SLOTS_C = 17'(SLOTS);
	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_HASH = 2'd1;
	localparam logic [1:0] F_MOD = 2'd2;
	localparam logic [1:0] F_PUSH = 2'd3;

	logic [1:0] state_q;
	logic [6:0] cnt_q;
	logic [63:0] hash_q;
	logic [HASH_BYTES*8-1:0] bytes_q;
	logic [SW-1:0] rem_q;
	logic [7:0] quo_q;
	item_t item_q;
	logic [V_W-1:0] mod_v;
	logic [47:0] mod_prod;
	logic [24:0] mod_qs;
	logic [24:0] mod_diff;
	logic [SW:0] mod_rem;

	assign item_ready = (state_q == F_IDLE) && !status.clearing;
	assign q_push = (state_q == F_PUSH) && !q_full;
	assign q_data.item = item_q;
	assign q_data.home = HOME_W'(rem_q);

	// The hash is reduced a byte at a time, most significant first. The partial
	// value stays below 256 * SLOTS, so a reciprocal estimate of the quotient is
	// at most one short and one compare and subtract finishes the remainder.
	// For each byte the estimate comes first, then the correction.
	assign mod_v = {rem_q, hash_q[63:56]};
	assign mod_prod = 48'(mod_v) * 48'(RECIP);
	assign mod_qs = 25'(quo_q) * 25'(SLOTS_C);
	assign mod_diff = 25'(mod_v) - mod_qs;
	assign mod_rem = mod_diff[SW:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (item_valid && item_ready) begin
						state_q <= F_HASH;
						cnt_q <= '0;
					end
				end
				F_HASH: begin
					if (cnt_q == 7'(HASH_BYTES - 1)) begin
						state_q <= F_MOD;
						cnt_q <= '0;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				F_MOD: begin
					if (cnt_q == 7'd15) begin
						state_q <= F_PUSH;
					end
					cnt_q <= cnt_q + 7'd1;
				end
				F_PUSH: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				item_q <= item;
				hash_q <= FNV_BASIS;
				rem_q <= '0;
				bytes_q <= {7'd0, item.family, item.proto, item.src_port, item.dst_port,
					item.src_addr_hi, item.src_addr_lo, item.dst_addr_hi, item.dst_addr_lo};
			end
			F_HASH: begin
				hash_q <= fnv_step(hash_q, bytes_q[HASH_BYTES*8-1 -: 8]);
				bytes_q <= bytes_q << 8;
			end
			F_MOD: begin
				if (!cnt_q[0]) begin
					quo_q <= mod_prod[31:24];
				end else begin
					hash_q <= hash_q << 8;
					if (mod_rem >= (SW+1)'(SLOTS)) begin
						rem_q <= SW'(mod_rem - (SW+1)'(SLOTS));
					end else begin
						rem_q <= mod_rem[SW-1:0];
					end
				end
			end
			default: begin
			end
		endcase
	end
endmodule

// ===== sv/ftt_queue.sv =====
// Two-entry queue of hashed jobs between the front and back ends.
`timescale 1ns / 1ps
module ftt_queue import ftt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_data,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output job_t head
);
	job_t ent_q [2];
	logic wr_q;
	logic rd_q;
	logic [1:0] count_q;

	assign full = count_q[1];
	assign not_empty = (count_q != 2'd0);
	assign head = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_data;
		end
	end
endmodule

// ===== sv/ftt_back.sv =====
// Back end: clears the table after reset, probes it, picks a victim, updates slots and emits events.
`timescale 1ns / 1ps
module ftt_back import ftt_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    q_not_empty,
	input  job_t    q_head,
	output logic    q_pop,
	output status_t status,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);
	localparam int SW = $clog2(SLOTS);
	localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);
	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_RD = 3'd2;
	localparam logic [2:0] ST_CHK = 3'd3;
	localparam logic [2:0] ST_SCAN = 3'd4;
	localparam logic [2:0] ST_WR = 3'd5;

	logic [2:0] state_q;
	logic [SW-1:0] clr_q;
	logic [SW-1:0] idx_q;
	logic [SW-1:0] cnt_q;
	logic [SW-1:0] slot_q;
	logic [SW:0] scan_q;
	logic scan_vld_s1;
	logic [SW-1:0] scan_idx_s1;
	logic [STAMP_W-1:0] best_q;
	logic [STAMP_W-1:0] ctr_q;
	logic found_q;
	job_t cur_q;
	entry_t ent_q;
	logic result_valid_q;
	result_t result_q;

	logic we;
	logic [SW-1:0] waddr;
	logic [SW-1:0] raddr;
	entry_t wdata;
	entry_t rdata;
	logic [MISC_W-1:0] misc;
	logic key_hit;
	logic emit;
	logic out_free;
	logic go;
	logic [31:0] slot_ext;

	ftt_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(SLOTS)
	) u_ram (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign status.clearing = (state_q == ST_CLEAR);
	assign q_pop = (state_q == ST_IDLE) && q_not_empty;
	assign result_valid = result_valid_q;
	assign result = result_q;

	assign misc = {cur_q.item.family, cur_q.item.proto, cur_q.item.src_port,
		cur_q.item.dst_port};
	assign key_hit = (rdata.misc == misc) && (rdata.src_hi == cur_q.item.src_addr_hi) &&
		(rdata.src_lo == cur_q.item.src_addr_lo) && (rdata.dst_hi == cur_q.item.dst_addr_hi) &&
		(rdata.dst_lo == cur_q.item.dst_addr_lo);

	assign raddr = (state_q == ST_SCAN) ? scan_q[SW-1:0] : idx_q;
	assign emit = (cur_q.item.operation == OP_DESTROY) || !found_q;
	assign out_free = !result_valid_q || result_ready;
	assign go = (state_q == ST_WR) && (!emit || out_free);
	assign slot_ext = {{(32-SW){1'b0}}, slot_q};

	always_comb begin
		we = 1'b0;
		waddr = slot_q;
		wdata = '0;
		if (state_q == ST_CLEAR) begin
			we = 1'b1;
			waddr = clr_q;
		end else if (go) begin
			if (cur_q.item.operation == OP_DESTROY) begin
				we = found_q;
			end else if (found_q) begin
				we = 1'b1;
				wdata = ent_q;
				wdata.stamp = ctr_q;
				if (cur_q.item.flow_mark_in != 32'd0) begin
					wdata.mark = cur_q.item.flow_mark_in;
				end
				wdata.orig_bytes = cur_q.item.orig_bytes_in;
				wdata.reply_bytes = cur_q.item.reply_bytes_in;
			end else begin
				we = 1'b1;
				wdata.stamp = ctr_q;
				wdata.src_hi = cur_q.item.src_addr_hi;
				wdata.src_lo = cur_q.item.src_addr_lo;
				wdata.dst_hi = cur_q.item.dst_addr_hi;
				wdata.dst_lo = cur_q.item.dst_addr_lo;
				wdata.misc = misc;
				wdata.mark = cur_q.item.flow_mark_in;
				wdata.orig_bytes = cur_q.item.orig_bytes_in;
				wdata.reply_bytes = cur_q.item.reply_bytes_in;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			ctr_q <= STAMP_W'(1);
			result_valid_q <= 1'b0;
			scan_vld_s1 <= 1'b0;
		end else begin
			if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			scan_vld_s1 <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + SW'(1);
					if (clr_q == LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_not_empty) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: state_q <= ST_CHK;
				ST_CHK: begin
					if (rdata.stamp == '0 || key_hit) begin
						state_q <= ST_WR;
					end else if (cnt_q == LAST) begin
						state_q <= (cur_q.item.operation == OP_DESTROY) ? ST_WR : ST_SCAN;
					end else begin
						state_q <= ST_RD;
					end
				end
				ST_SCAN: begin
					if (scan_q != (SW+1)'(SLOTS)) begin
						scan_vld_s1 <= 1'b1;
					end
					if (scan_vld_s1 && scan_idx_s1 == LAST) begin
						state_q <= ST_WR;
					end
				end
				ST_WR: begin
					if (go) begin
						state_q <= ST_IDLE;
						if (cur_q.item.operation == OP_NEW) begin
							ctr_q <= (ctr_q == STAMP_MAX) ? STAMP_W'(1) : ctr_q + STAMP_W'(1);
						end
						if (emit) begin
							result_valid_q <= 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		scan_idx_s1 <= scan_q[SW-1:0];
		case (state_q)
			ST_IDLE: begin
				cur_q <= q_head;
				idx_q <= q_head.home[SW-1:0];
				slot_q <= q_head.home[SW-1:0];
				cnt_q <= '0;
				found_q <= 1'b0;
				scan_q <= '0;
			end
			ST_CHK: begin
				if (rdata.stamp == '0) begin
					// A destroy that misses reports the home slot.
					if (cur_q.item.operation == OP_NEW) begin
						slot_q <= idx_q;
					end
				end else if (key_hit) begin
					slot_q <= idx_q;
					found_q <= 1'b1;
					ent_q <= rdata;
				end else begin
					idx_q <= (idx_q == LAST) ? '0 : idx_q + SW'(1);
					cnt_q <= cnt_q + SW'(1);
				end
			end
			ST_SCAN: begin
				if (scan_q != (SW+1)'(SLOTS)) begin
					scan_q <= scan_q + (SW+1)'(1);
				end
				// Strict compare keeps the lowest index on equal stamps.
				if (scan_vld_s1 && (scan_idx_s1 == '0 || rdata.stamp < best_q)) begin
					best_q <= rdata.stamp;
					slot_q <= scan_idx_s1;
				end
			end
			ST_WR: begin
				if (go && emit) begin
					result_q.event_kind <= (cur_q.item.operation == OP_DESTROY) ? EV_END : EV_START;
					result_q.slot <= slot_ext[SLOT_OUT_W-1:0];
					result_q.proto_out <= cur_q.item.proto;
					result_q.family_out <= cur_q.item.family;
					result_q.flow_mark_out <= cur_q.item.flow_mark_in;
					result_q.orig_bytes_out <= cur_q.item.orig_bytes_in;
					result_q.reply_bytes_out <= cur_q.item.reply_bytes_in;
				end
			end
			default: begin
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_ctr_nonzero: assert property (@(posedge clk) disable iff (!arst_n) ctr_q != '0)
		else $error("touch counter reached zero");
	a_chk_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CHK |-> $past(state_q) == ST_RD)
		else $error("probe check without a read");
	a_new_stamp: assert property (@(posedge clk) disable iff (!arst_n)
		(go && cur_q.item.operation == OP_NEW) |-> (we && wdata.stamp != '0))
		else $error("new flow written with an empty stamp");
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !result_valid_q && !q_pop)
		else $error("activity during the clearing pass");
`endif
endmodule

// ===== sv/flow_table_tracker.sv =====
// Flow table tracker: connection flow table with linear probing and LRU eviction.
// The front end hashes the tuple byte by byte and reduces the hash to a home slot; the back
// end then passes through its idle state, a read and a check state per probe and a write state.
// A new flow that finds the table full adds a scan of the whole table for the oldest slot.
// The front end takes no new word until it has pushed the job of the last one to the queue.
// After reset the back end clears the table store; no word is taken until it is done.
`timescale 1ns / 1ps
module flow_table_tracker import ftt_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);
	// The front end hashes one word while the back end works on the previous
	// one; the two-entry queue between them lets each side stall on its own.
	status_t status;
	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_not_empty;
	job_t q_in;
	job_t q_head;

	ftt_front #(
		.SLOTS(SLOTS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.status(status),
		.q_full(q_full),
		.q_push(q_push),
		.q_data(q_in)
	);

	ftt_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_data(q_in),
		.full(q_full),
		.pop(q_pop),
		.not_empty(q_not_empty),
		.head(q_head)
	);

	// The back end owns the table store and the output register, so a
	// finished word can wait there while the next job is probed.
	ftt_back #(
		.SLOTS(SLOTS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_not_empty(q_not_empty),
		.q_head(q_head),
		.q_pop(q_pop),
		.status(status),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);
endmodule

// ===== test/tb.sv =====
// Testbench of the flow table tracker: directed flow events and random traffic.
`timescale 1ns / 1ps
module tb;
	import ftt_pkg::*;

	localparam int N_SLOTS = SLOTS_DEF;
	localparam logic [63:0] FNV_MUL = 64'h100000001b3;
	// The longest correct wait is a full-table miss: hashing, a whole-table probe
	// and the eviction scan. This is several times that.
	localparam int STALL_LIMIT = 100000;
	localparam int POOL_N = 64;

	// What a directed row expects to see, where it is obvious.
	typedef enum int {SEE_ANY, SEE_START, SEE_END, SEE_NONE} seen_e;

	typedef struct {
		logic        op;
		int          key_id;
		logic [31:0] mark;
		logic [63:0] bytes;
		seen_e       seen;
	} row_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_ready;
	item_t   item = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	// Shadow of the flow table.
	logic [STAMP_W-1:0] tbl_stamp [N_SLOTS];
	logic [296:0]       tbl_tuple [N_SLOTS];
	logic [31:0]        tbl_mark [N_SLOTS];
	logic [63:0]        tbl_orig [N_SLOTS];
	logic [63:0]        tbl_reply [N_SLOTS];
	logic [STAMP_W-1:0] next_stamp;

	result_t pending_events[$];
	int      words_in = 0;
	int      errs = 0;
	int      quiet_cycles = 0;
	bit      no_idle = 1'b0;
	bit      last_emitted;
	logic    last_kind;

	item_t keys [0:5];
	item_t pool [POOL_N];
	row_t  rows [$];

	flow_table_tracker u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	always #4 clk = ~clk;

	// FNV-1a 64 over the 38 tuple bytes, most significant byte first.
	function automatic logic [63:0] tuple_fnv(input item_t w);
		logic [303:0] msg;
		logic [63:0] h;
		msg = {7'd0, w.family, w.proto, w.src_port, w.dst_port,
			w.src_addr_hi, w.src_addr_lo, w.dst_addr_hi, w.dst_addr_lo};
		h = 64'hcbf29ce484222325;
		for (int i = 37; i >= 0; i--) begin
			h = h ^ {56'd0, msg[i*8 +: 8]};
			h = h * FNV_MUL;
		end
		return h;
	endfunction

	function automatic logic [296:0] tuple_of(input item_t w);
		return {w.family, w.proto, w.src_port, w.dst_port,
			w.src_addr_hi, w.src_addr_lo, w.dst_addr_hi, w.dst_addr_lo};
	endfunction

	function automatic logic [STAMP_W-1:0] grab_stamp();
		logic [STAMP_W-1:0] s;
		s = next_stamp;
		next_stamp = next_stamp + 1'b1;
		if (next_stamp == '0)
			next_stamp = STAMP_W'(1);
		return s;
	endfunction

	function automatic void clear_entry(input int i);
		tbl_stamp[i] = '0;
		tbl_tuple[i] = '0;
		tbl_mark[i] = '0;
		tbl_orig[i] = '0;
		tbl_reply[i] = '0;
	endfunction

	// Applies one flow event to the shadow table; returns 1 with the event to emit.
	function automatic bit apply_flow_event(input item_t w, output result_t ev);
		logic [296:0] tup;
		int home, idx, at, free_at;
		bit hit, has_free;
		logic [STAMP_W-1:0] low;
		tup = tuple_of(w);
		home = int'(tuple_fnv(w) % N_SLOTS);
		at = home;
		hit = 0;
		has_free = 0;
		free_at = 0;
		ev = '0;
		for (int k = 0; k < N_SLOTS; k++) begin
			idx = (home + k) % N_SLOTS;
			if (tbl_stamp[idx] == '0) begin
				has_free = 1;
				free_at = idx;
				break;
			end
			if (tbl_tuple[idx] == tup) begin
				hit = 1;
				at = idx;
				break;
			end
		end
		if (w.operation == OP_DESTROY) begin
			if (hit)
				clear_entry(at);
		end else begin
			if (hit) begin
				tbl_stamp[at] = grab_stamp();
				if (w.flow_mark_in != 0)
					tbl_mark[at] = w.flow_mark_in;
				tbl_orig[at] = w.orig_bytes_in;
				tbl_reply[at] = w.reply_bytes_in;
				return 0;
			end
			if (has_free) begin
				at = free_at;
			end else begin
				// Evict the least recently touched slot, lowest index on a tie.
				low = tbl_stamp[0];
				at = 0;
				for (int k = 1; k < N_SLOTS; k++)
					if (tbl_stamp[k] < low) begin
						low = tbl_stamp[k];
						at = k;
					end
			end
			tbl_stamp[at] = grab_stamp();
			tbl_tuple[at] = tup;
			tbl_mark[at] = w.flow_mark_in;
			tbl_orig[at] = w.orig_bytes_in;
			tbl_reply[at] = w.reply_bytes_in;
		end
		ev.event_kind = w.operation;
		ev.slot = at[SLOT_OUT_W-1:0];
		ev.proto_out = w.proto;
		ev.family_out = w.family;
		ev.flow_mark_out = w.flow_mark_in;
		ev.orig_bytes_out = w.orig_bytes_in;
		ev.reply_bytes_out = w.reply_bytes_in;
		return 1;
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			errs++;
		end
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic item_t random_tuple();
		item_t w;
		w = '0;
		w.family = 1'($urandom_range(1));
		w.proto = 8'($urandom);
		w.src_port = 16'($urandom);
		w.dst_port = 16'($urandom);
		w.src_addr_hi = rand64();
		w.src_addr_lo = rand64();
		w.dst_addr_hi = rand64();
		w.dst_addr_lo = rand64();
		// Half the flows of family zero look like real IPv4 ones.
		if (w.family == 1'b0 && $urandom_range(1)) begin
			w.src_addr_hi = '0;
			w.dst_addr_hi = '0;
			w.src_addr_lo[63:32] = '0;
			w.dst_addr_lo[63:32] = '0;
		end
		return w;
	endfunction

	function automatic item_t with_payload(input item_t w, input logic op);
		w.operation = op;
		w.flow_mark_in = ($urandom_range(3) == 0) ? 32'd0 : $urandom;
		w.orig_bytes_in = rand64();
		w.reply_bytes_in = rand64();
		return w;
	endfunction

	// Both the acceptance of a word and the arrival of an event are seen here.
	always @(posedge clk) begin
		result_t ev, want;
		if (arst_n && item_valid && item_ready) begin
			words_in++;
			last_emitted = apply_flow_event(item, ev);
			last_kind = ev.event_kind;
			if (last_emitted)
				pending_events.push_back(ev);
		end
		if (arst_n && result_valid && result_ready) begin
			if (pending_events.size() == 0) begin
				$error("event with nothing expected: slot %h", result.slot);
				errs++;
			end else begin
				want = pending_events.pop_front();
				check_field("event_kind", want.event_kind, result.event_kind);
				check_field("slot", want.slot, result.slot);
				check_field("proto_out", want.proto_out, result.proto_out);
				check_field("family_out", want.family_out, result.family_out);
				check_field("flow_mark_out", want.flow_mark_out, result.flow_mark_out);
				check_field("orig_bytes_out", want.orig_bytes_out, result.orig_bytes_out);
				check_field("reply_bytes_out", want.reply_bytes_out, result.reply_bytes_out);
			end
		end
		if ((item_valid && item_ready) || (result_valid && result_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// The receiver holds off now and then, unless idling is switched off.
	always @(negedge clk)
		result_ready = arst_n && (no_idle || $urandom_range(99) >= 15);

	task automatic send_word(input item_t w);
		int seen_before;
		if (!no_idle)
			while ($urandom_range(99) < 15) begin
				item_valid = 1'b0;
				@(negedge clk);
			end
		item = w;
		item_valid = 1'b1;
		seen_before = words_in;
		do @(negedge clk); while (words_in == seen_before);
	endtask

	task automatic wait_drained();
		item_valid = 1'b0;
		while (pending_events.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		item_t w, probe_w;
		int home_a, found;
		row_t r;

		for (int i = 0; i < N_SLOTS; i++)
			clear_entry(i);
		next_stamp = STAMP_W'(1);

		// All-zero tuple, all-ones tuple and a plain IPv4 TCP flow.
		keys[0] = '0;
		keys[1] = '1;
		keys[2] = '0;
		keys[2].proto = 8'd6;
		keys[2].src_port = 16'd40000;
		keys[2].dst_port = 16'd443;
		keys[2].src_addr_lo = 64'h0a00_0001;
		keys[2].dst_addr_lo = 64'hc0a8_0101;
		// Two more flows that share one home slot, to open a gap in a probe chain.
		keys[3] = random_tuple();
		home_a = int'(tuple_fnv(keys[3]) % N_SLOTS);
		found = 0;
		while (!found) begin
			probe_w = random_tuple();
			if (int'(tuple_fnv(probe_w) % N_SLOTS) == home_a)
				found = 1;
		end
		keys[4] = probe_w;
		keys[5] = random_tuple();

		rows = '{
			'{OP_NEW,     0, 32'd0,        64'd0, SEE_START},
			'{OP_NEW,     0, 32'd0,        64'd0, SEE_NONE},
			'{OP_NEW,     1, 32'hffffffff, '1,    SEE_START},
			'{OP_NEW,     1, 32'd0,        '1,    SEE_NONE},
			'{OP_DESTROY, 1, 32'hffffffff, '1,    SEE_END},
			'{OP_DESTROY, 1, 32'd0,        64'd0, SEE_END},
			'{OP_NEW,     2, 32'd5,        64'd1500, SEE_START},
			'{OP_NEW,     2, 32'd7,        64'd3000, SEE_NONE},
			'{OP_DESTROY, 2, 32'd7,        64'd3000, SEE_END},
			'{OP_NEW,     3, 32'd1,        64'd64, SEE_START},
			'{OP_NEW,     4, 32'd2,        64'd64, SEE_START},
			'{OP_NEW,     5, 32'd3,        64'd64, SEE_START},
			'{OP_DESTROY, 3, 32'd0,        64'd0, SEE_END},
			// The second flow now sits behind the gap and is opened afresh.
			'{OP_NEW,     4, 32'd9,        64'd128, SEE_START},
			'{OP_NEW,     4, 32'd0,        64'd256, SEE_ANY},
			'{OP_DESTROY, 4, 32'd0,        64'd0, SEE_END},
			'{OP_DESTROY, 4, 32'd0,        64'd0, SEE_END},
			'{OP_NEW,     5, 32'd0,        64'd1, SEE_NONE},
			'{OP_DESTROY, 5, 32'd0,        64'd0, SEE_END},
			'{OP_DESTROY, 0, 32'd0,        64'd0, SEE_END}
		};

		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		foreach (rows[i]) begin
			r = rows[i];
			w = keys[r.key_id];
			w.operation = r.op;
			w.flow_mark_in = r.mark;
			w.orig_bytes_in = r.bytes;
			w.reply_bytes_in = ~r.bytes;
			send_word(w);
			if ((r.seen == SEE_NONE && last_emitted) ||
				(r.seen == SEE_START && !(last_emitted && last_kind == EV_START)) ||
				(r.seen == SEE_END && !(last_emitted && last_kind == EV_END))) begin
				$error("row %0d: event_kind expected %s, emitted %0b kind %0b",
					i, r.seen.name(), last_emitted, last_kind);
				errs++;
			end
		end

		// Random traffic over a small pool of flows, with some one-off noise.
		for (int i = 0; i < POOL_N; i++)
			pool[i] = random_tuple();
		for (int n = 0; n < 1080; n++) begin
			int pick;
			no_idle = (n >= 400 && n < 600);
			pick = $urandom_range(99);
			if (pick < 60)
				w = with_payload(pool[$urandom_range(POOL_N - 1)], OP_NEW);
			else if (pick < 90)
				w = with_payload(pool[$urandom_range(POOL_N - 1)], OP_DESTROY);
			else
				w = with_payload(random_tuple(), 1'($urandom_range(1)));
			send_word(w);
			// Hold the sender once until every event is out.
			if (n == 800)
				wait_drained();
		end

		wait_drained();
		repeat (200) @(negedge clk);
		if (errs == 0 && pending_events.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
